// ===== design/nfa_pkg.sv =====
`timescale 1ns / 1ps

package nfa_pkg;

    localparam int NUM_STATES_DEF  = 8;
    localparam int NUM_SYMBOLS_DEF = 3;

    // Matrix layout: bit from*ROW_W+to
    localparam int ROW_W       = 8;
    localparam int MATRIX_W    = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int STATE_IDX_W = 3;
    localparam int SYMBOL_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT    = 3'd5;

    localparam logic [SYMBOL_W-1:0] SYM_A = 2'd0;
    localparam logic [SYMBOL_W-1:0] SYM_B = 2'd1;
    localparam logic [SYMBOL_W-1:0] SYM_C = 2'd2;

    localparam logic MODE_END = 1'b1;

    typedef enum logic [2:0] {
        OP_SYM_A,
        OP_SYM_B,
        OP_SYM_C,
        OP_KILL,
        OP_END
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_APPLY
    } t_back_state;

endpackage

// ===== design/nfa_string_acceptor.sv =====
`timescale 1ns / 1ps
// An end-of-string item gives its verdict after the back part has closed and applied the set;
// the epsilon closure iterates in the back part, one expansion per cycle until the set stops
// growing, and the back part takes the next item only when it is through with the last.
// A two-entry queue lets the front take items while the back is still closing.
// Reset (synchronous, active low) clears the queue, the pending set, the configuration registers and the output valid.
module nfa_string_acceptor #(
    parameter int NUM_STATES  = nfa_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nfa_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [nfa_pkg::SYMBOL_W-1:0]    i_symbol,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic                            o_dead,
    input  logic                            i_cfg_wr_en,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import nfa_pkg::*;

    logic push;
    t_op  push_op;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_op  q_head;

    nfa_front #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_symbol   (i_symbol),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_op  (push_op)
    );

    nfa_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (q_pop),
        .o_head    (q_head),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    nfa_back #(
        .NUM_STATES (NUM_STATES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_head    (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_accepted  (o_accepted),
        .o_dead      (o_dead)
    );

endmodule

// ===== design/nfa_front.sv =====
`timescale 1ns / 1ps

module nfa_front #(
    parameter int NUM_SYMBOLS = nfa_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [nfa_pkg::SYMBOL_W-1:0]  i_symbol,
    input  logic                          i_q_full,
    output logic                          o_push,
    output nfa_pkg::t_op                  o_push_op
);
    import nfa_pkg::*;

    localparam logic [SYMBOL_W:0] SYM_LIMIT = (SYMBOL_W+1)'(NUM_SYMBOLS);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Symbols beyond the alphabet have no edges: kill the set
    always_comb begin
        priority if (i_mode == MODE_END) begin
            o_push_op = OP_END;
        end else if ({1'b0, i_symbol} >= SYM_LIMIT) begin
            o_push_op = OP_KILL;
        end else begin
            unique case (i_symbol)
                SYM_A:   o_push_op = OP_SYM_A;
                SYM_B:   o_push_op = OP_SYM_B;
                SYM_C:   o_push_op = OP_SYM_C;
                default: o_push_op = OP_KILL;
            endcase
        end
    end

endmodule

// ===== design/nfa_queue.sv =====
`timescale 1ns / 1ps

module nfa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nfa_pkg::t_op  i_push_op,
    input  logic          i_pop,
    output nfa_pkg::t_op  o_head,
    output logic          o_full,
    output logic          o_empty
);
    import nfa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/nfa_back.sv =====
`timescale 1ns / 1ps

module nfa_back #(
    parameter int NUM_STATES = nfa_pkg::NUM_STATES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  nfa_pkg::t_op                    i_q_head,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic                            o_dead
);
    import nfa_pkg::*;

    logic [MATRIX_W-1:0]    r_trans_a;
    logic [MATRIX_W-1:0]    r_trans_b;
    logic [MATRIX_W-1:0]    r_trans_c;
    logic [MATRIX_W-1:0]    r_eps;
    logic [STATE_IDX_W-1:0] r_start;
    logic [ROW_W-1:0]       r_accept;

    t_back_state            r_state;
    t_back_state            n_state;
    t_op                    r_op;
    logic [NUM_STATES-1:0]  r_set;
    logic [NUM_STATES-1:0]  r_pending;
    logic                   r_at_start;
    logic                   r_out_valid;
    logic                   r_accepted;
    logic                   r_dead;

    logic [MATRIX_W-1:0]    sel_matrix;
    logic [NUM_STATES-1:0]  start_set;
    logic [NUM_STATES-1:0]  eps_img;
    logic [NUM_STATES-1:0]  grown_set;
    logic [NUM_STATES-1:0]  trans_img;
    logic                   out_free;
    logic                   load_set;
    logic                   grow_set;
    logic                   commit;
    logic                   out_load;

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_dead      = r_dead;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_op)
            OP_SYM_A: sel_matrix = r_trans_a;
            OP_SYM_B: sel_matrix = r_trans_b;
            OP_SYM_C: sel_matrix = r_trans_c;
            default:  sel_matrix = '0;
        endcase
    end

    // Images of the current set: one row per active state, ORed together
    always_comb begin
        eps_img   = '0;
        trans_img = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            start_set[s] = (r_start == STATE_IDX_W'(s));
            if (r_set[s]) begin
                eps_img   = eps_img   | r_eps[s*ROW_W +: NUM_STATES];
                trans_img = trans_img | sel_matrix[s*ROW_W +: NUM_STATES];
            end
        end
        grown_set = r_set | eps_img;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) n_state = ST_CLOSE;
            end
            ST_CLOSE: begin
                // closure done once an expansion adds nothing
                if (grown_set == r_set) n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (r_op != OP_END || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
        load_set = o_q_pop;
        grow_set = (r_state == ST_CLOSE);
        commit   = (r_state == ST_APPLY) && (r_op != OP_END || out_free);
        out_load = commit && (r_op == OP_END);
    end

    always_ff @(posedge i_clk) begin
        if (load_set) begin
            r_op  <= i_q_head;
            r_set <= r_at_start ? start_set : r_pending;
        end else if (grow_set) begin
            r_set <= grown_set;
        end
        if (out_load) begin
            r_accepted <= |(r_set & r_accept[NUM_STATES-1:0]);
            r_dead     <= ~|r_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= '0;
            r_at_start  <= 1'b1;
            r_out_valid <= 1'b0;
            r_trans_a   <= '0;
            r_trans_b   <= '0;
            r_trans_c   <= '0;
            r_eps       <= '0;
            r_start     <= '0;
            r_accept    <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                // end of string rearms, a symbol advances the set
                if (r_op == OP_END) begin
                    r_pending  <= '0;
                    r_at_start <= 1'b1;
                end else begin
                    r_pending  <= trans_img;
                    r_at_start <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_TRANS_A: r_trans_a <= i_cfg_data;
                    CFG_TRANS_B: r_trans_b <= i_cfg_data;
                    CFG_TRANS_C: r_trans_c <= i_cfg_data;
                    CFG_EPS:     r_eps     <= i_cfg_data;
                    CFG_START:   r_start   <= i_cfg_data[STATE_IDX_W-1:0];
                    CFG_ACCEPT:  r_accept  <= i_cfg_data[ROW_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

endmodule

// ===== design/nfa_chk.sv =====
`timescale 1ns / 1ps

module nfa_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [nfa_pkg::SYMBOL_W-1:0]    i_symbol,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic                            o_accepted,
    input  logic                            o_dead,
    input  logic                            i_cfg_wr_en,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_accepted) && $stable(o_dead))
        else $error("stalled result changed or dropped");

    // an accepting state lies in a non-empty set
    a_accept_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> !o_dead)
        else $error("accepted verdict on a dead set");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a verdict never appears straight out of reset
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!o_out_valid) && $past(i_rst_n) && $rose(o_out_valid) |-> $past(i_rst_n, 2))
        else $error("result appeared straight out of reset");

endmodule

bind nfa_string_acceptor nfa_chk u_nfa_chk (.*);
